// ===== hdl/smx_pkg.sv =====
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types, codes and default sizes for the stack machine executor.
// ----------------------------------------------------------------------------
package smx_pkg;

   // default sizes
   localparam int unsigned STACK_DEPTH_DFLT = 16;
   localparam int unsigned VAR_SLOTS_DFLT   = 16;

   // number of variable slots that a 4-bit index can reach
   localparam int unsigned VAR_INDEX_REACH  = 16;

   typedef logic signed [31:0] word_type;
   typedef logic [4:0]         depth_type;
   typedef logic [3:0]         index_type;

   // instruction codes
   typedef enum logic [2:0] {
      ACT_PUSH    = 3'd0,
      ACT_POP     = 3'd1,
      ACT_ADD     = 3'd2,
      ACT_SUB     = 3'd3,
      ACT_LESS    = 3'd4,
      ACT_GET     = 3'd5,
      ACT_SAVE    = 3'd6,
      ACT_RESERVE = 3'd7
   } action_type;

   // result status codes
   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_UNDER = 2'd1,
      STS_OVER  = 2'd2,
      STS_NOVAR = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic {
      SEQ_IDLE,
      SEQ_EXEC
   } seq_state_type;

   // state of one variable slot as seen by the sequencer
   typedef struct packed {
      logic in_range;
      logic reserved;
   } slot_status_type;

endpackage

// ===== hdl/smx_if.sv =====
// ----------------------------------------------------------------------------
// smx_req_if / smx_rsp_if
// Valid/ready channels for instructions and for results.
// ----------------------------------------------------------------------------
interface smx_req_if;
   import smx_pkg::*;

   logic       valid;
   logic       ready;
   action_type action;
   word_type   immediate;
   index_type  var_index;

   modport source (output valid, output action, output immediate, output var_index,
                   input ready);
   modport sink   (input valid, input action, input immediate, input var_index,
                   output ready);
endinterface

interface smx_rsp_if;
   import smx_pkg::*;

   logic       valid;
   logic       ready;
   word_type   top_value;
   depth_type  depth;
   status_type status;

   modport source (output valid, output top_value, output depth, output status,
                   input ready);
   modport sink   (input valid, input top_value, input depth, input status,
                   output ready);
endinterface

// ===== hdl/smx_stack_mem.sv =====
// ----------------------------------------------------------------------------
// smx_stack_mem
// Operand stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module smx_stack_mem #(
   parameter int unsigned STACK_DEPTH = smx_pkg::STACK_DEPTH_DFLT
) (
   input  logic                               clock,
   input  logic                               rd_en,
   input  logic [$clog2(STACK_DEPTH)-1:0]     rd_addr,
   output smx_pkg::word_type                  rd_data,
   input  logic                               wr_en,
   input  logic [$clog2(STACK_DEPTH)-1:0]     wr_addr,
   input  smx_pkg::word_type                  wr_data
);
   import smx_pkg::*;

   word_type mem [STACK_DEPTH];
   word_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/smx_var_store.sv =====
// ----------------------------------------------------------------------------
// smx_var_store
// Variable slots with reserve marks; the marks clear at reset, the data does not.
// ----------------------------------------------------------------------------
module smx_var_store #(
   parameter int unsigned VAR_SLOTS = smx_pkg::VAR_SLOTS_DFLT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  smx_pkg::index_type       rd_idx,
   output smx_pkg::word_type        rd_data,
   input  smx_pkg::index_type       op_idx,
   output smx_pkg::slot_status_type op_slot,
   input  logic                     wr_en,
   input  logic                     wr_mark,
   input  smx_pkg::word_type        wr_data
);
   import smx_pkg::*;

   localparam int unsigned VarUsed = (VAR_SLOTS < VAR_INDEX_REACH) ? VAR_SLOTS
                                                                  : VAR_INDEX_REACH;
   localparam int unsigned VIW     = (VarUsed > 1) ? $clog2(VarUsed) : 1;

   word_type           mem [VarUsed];
   word_type           rd_data_ff;
   logic [VarUsed-1:0] reserved_ff;
   logic [VIW-1:0]     rd_addr;
   logic [VIW-1:0]     op_addr;
   logic               rd_in_range;
   logic               op_in_range;

   // slot decode
   assign rd_in_range = (32'(rd_idx) < 32'(VarUsed));
   assign op_in_range = (32'(op_idx) < 32'(VarUsed));
   assign rd_addr     = VIW'(rd_idx);
   assign op_addr     = VIW'(op_idx);

   assign op_slot.in_range = op_in_range;
   assign op_slot.reserved = op_in_range && reserved_ff[op_addr];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en && op_in_range) begin
         mem[op_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en && rd_in_range) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // reserve marks
   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= '0;
      end else if (wr_en && wr_mark && op_in_range) begin
         reserved_ff[op_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/stack_machine_executor.sv =====
// Timing: the instruction is latched on transfer, and its result is registered
// on commit in the execute state, which waits while an earlier result is still
// held on the result channel. A new instruction is taken only in the idle state;
// the stack and variable memories are read on transfer, ahead of the execute state.
// Reset: synchronous; the stack empties and all variable reserve marks clear,
// memory contents are left as they are and no clearing pass is needed.
// ----------------------------------------------------------------------------
// stack_machine_executor
// Executes one stack-machine instruction per transfer and returns the top of
// stack, the depth and a status for each.
// ----------------------------------------------------------------------------
module stack_machine_executor #(
   parameter int unsigned STACK_DEPTH = smx_pkg::STACK_DEPTH_DFLT,
   parameter int unsigned VAR_SLOTS   = smx_pkg::VAR_SLOTS_DFLT
) (
   input  logic      clock,
   input  logic      reset,
   smx_req_if.sink   req_ch,
   smx_rsp_if.source rsp_ch
);
   import smx_pkg::*;

   localparam int unsigned SAW = $clog2(STACK_DEPTH);
   localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
   localparam logic [SPW-1:0] SpFull = SPW'(STACK_DEPTH);
   localparam logic [SPW-1:0] SpOne  = SPW'(1);
   localparam logic [SPW-1:0] SpTwo  = SPW'(2);

   seq_state_type   state_ff, state_in;
   logic            req_ready;
   logic            accept;
   logic            commit;
   logic            rsp_free;

   // latched instruction
   action_type      act_ff;
   word_type        imm_ff;
   index_type       idx_ff;

   // stack pointer and cached top entry
   logic [SPW-1:0]  sp_ff, sp_in;
   word_type        top_ff, top_in;

   // memory ports
   word_type        stk_rd_data;
   logic            stk_we;
   logic [SAW-1:0]  stk_waddr;
   word_type        stk_wdata;
   word_type        var_rd_data;
   slot_status_type op_slot;
   logic            var_we;
   logic            var_mark;
   word_type        var_wdata;

   word_type        alu_res;
   status_type      status;

   // result register
   logic            rsp_valid_ff;
   word_type        rsp_top_ff;
   depth_type       rsp_depth_ff;
   status_type      rsp_status_ff;

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_ch.valid) begin
               state_in = SEQ_EXEC;
            end
         end
         SEQ_EXEC: begin
            if (rsp_free) begin
               state_in = SEQ_IDLE;
            end
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: req_ready = 1'b1;
         SEQ_EXEC: commit    = rsp_free;
      endcase
   end

   assign accept       = req_ch.valid && req_ready;
   assign req_ch.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture the instruction on transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_ch.action;
         imm_ff <= req_ch.immediate;
         idx_ff <= req_ch.var_index;
      end
   end

   // memories, read on transfer, written on commit
   smx_stack_mem #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (SAW'(sp_ff - SpTwo)),
      .rd_data (stk_rd_data),
      .wr_en   (commit && stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata)
   );

   smx_var_store #(
      .VAR_SLOTS (VAR_SLOTS)
   ) u_vars (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_idx  (req_ch.var_index),
      .rd_data (var_rd_data),
      .op_idx  (idx_ff),
      .op_slot (op_slot),
      .wr_en   (commit && var_we),
      .wr_mark (var_mark),
      .wr_data (var_wdata)
   );

   // binary operation on the entry below the top and the top
   always_comb begin
      case (act_ff)
         ACT_ADD: alu_res = stk_rd_data + top_ff;
         ACT_SUB: alu_res = stk_rd_data - top_ff;
         default: alu_res = {31'b0, (stk_rd_data < top_ff)};
      endcase
   end

   // instruction decode and next stack state
   always_comb begin
      sp_in     = sp_ff;
      top_in    = top_ff;
      status    = STS_OK;
      stk_we    = 1'b0;
      stk_waddr = SAW'(sp_ff);
      stk_wdata = imm_ff;
      var_we    = 1'b0;
      var_mark  = 1'b0;
      var_wdata = top_ff;
      unique case (act_ff)
         ACT_PUSH: begin
            if (sp_ff == SpFull) begin
               status = STS_OVER;
            end else begin
               stk_we = 1'b1;
               top_in = imm_ff;
               sp_in  = sp_ff + SpOne;
            end
         end
         ACT_POP: begin
            if (sp_ff == '0) begin
               status = STS_UNDER;
            end else begin
               top_in = stk_rd_data;
               sp_in  = sp_ff - SpOne;
            end
         end
         ACT_ADD, ACT_SUB, ACT_LESS: begin
            if (sp_ff < SpTwo) begin
               status = STS_UNDER;
            end else begin
               stk_we    = 1'b1;
               stk_waddr = SAW'(sp_ff - SpTwo);
               stk_wdata = alu_res;
               top_in    = alu_res;
               sp_in     = sp_ff - SpOne;
            end
         end
         ACT_GET: begin
            if (!op_slot.reserved) begin
               status = STS_NOVAR;
            end else if (sp_ff == SpFull) begin
               status = STS_OVER;
            end else begin
               stk_we    = 1'b1;
               stk_wdata = var_rd_data;
               top_in    = var_rd_data;
               sp_in     = sp_ff + SpOne;
            end
         end
         ACT_SAVE: begin
            if (sp_ff == '0) begin
               status = STS_UNDER;
            end else if (!op_slot.reserved) begin
               status = STS_NOVAR;
            end else begin
               var_we = 1'b1;
            end
         end
         ACT_RESERVE: begin
            if (!op_slot.in_range) begin
               status = STS_NOVAR;
            end else begin
               var_we    = 1'b1;
               var_mark  = 1'b1;
               var_wdata = '0;
            end
         end
      endcase
   end

   // stack pointer and cached top
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else if (commit) begin
         sp_ff <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         top_ff <= top_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_top_ff    <= (sp_in == '0) ? '0 : top_in;
         rsp_depth_ff  <= 5'(sp_in);
         rsp_status_ff <= status;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.top_value = rsp_top_ff;
   assign rsp_ch.depth     = rsp_depth_ff;
   assign rsp_ch.status    = rsp_status_ff;

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stack_machine_executor. A shadow copy of the operand
// stack and the variable slots predicts top of stack, depth and status for
// every instruction transfer; each result transfer is checked in order.
// Directed tests cover the error cases and wrap-around, then random programs
// run with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import smx_pkg::*;

   localparam int unsigned STACK_DEPTH = STACK_DEPTH_DFLT;
   localparam int unsigned VAR_SLOTS   = VAR_SLOTS_DFLT;

   typedef struct {
      word_type   top_value;
      depth_type  depth;
      status_type status;
   } stack_view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   smx_req_if req_if ();
   smx_rsp_if rsp_if ();

   stack_machine_executor #(
      .STACK_DEPTH(STACK_DEPTH),
      .VAR_SLOTS  (VAR_SLOTS)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if)
   );

   // shadow state of the executor
   word_type    shadow_stack [STACK_DEPTH];
   int unsigned shadow_sp = 0;
   word_type    shadow_vars [VAR_SLOTS];
   bit          shadow_reserved [VAR_SLOTS];

   stack_view_type expected_views [$];

   int  mismatch_count = 0;
   int  instructions_sent = 0;
   int  results_checked = 0;
   int  status_seen [4];
   int  deepest_stack = 0;
   bit  steady_sender = 1'b0;
   bit  steady_receiver = 1'b0;

   // clock
   always #5 clock = ~clock;

   // run limit
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic bit slot_reserved(index_type idx);
      return int'(idx) < VAR_SLOTS && shadow_reserved[idx];
   endfunction

   // execute one instruction on the shadow state and return the stack view
   function automatic stack_view_type step_shadow(action_type act, word_type imm,
                                                  index_type idx);
      stack_view_type view;
      status_type     sts;
      word_type       lhs;
      word_type       rhs;
      sts = STS_OK;
      case (act)
         ACT_PUSH: begin
            if (shadow_sp >= STACK_DEPTH) sts = STS_OVER;
            else begin
               shadow_stack[shadow_sp] = imm;
               shadow_sp++;
            end
         end
         ACT_POP: begin
            if (shadow_sp == 0) sts = STS_UNDER;
            else shadow_sp--;
         end
         ACT_ADD, ACT_SUB, ACT_LESS: begin
            if (shadow_sp < 2) sts = STS_UNDER;
            else begin
               lhs = shadow_stack[shadow_sp - 2];
               rhs = shadow_stack[shadow_sp - 1];
               case (act)
                  ACT_ADD: shadow_stack[shadow_sp - 2] = lhs + rhs;
                  ACT_SUB: shadow_stack[shadow_sp - 2] = lhs - rhs;
                  default: shadow_stack[shadow_sp - 2] = (lhs < rhs) ? 32'sd1 : 32'sd0;
               endcase
               shadow_sp--;
            end
         end
         ACT_GET: begin
            // unreserved slot wins over a full stack
            if (!slot_reserved(idx)) sts = STS_NOVAR;
            else if (shadow_sp >= STACK_DEPTH) sts = STS_OVER;
            else begin
               shadow_stack[shadow_sp] = shadow_vars[idx];
               shadow_sp++;
            end
         end
         ACT_SAVE: begin
            // empty stack wins over an unreserved slot
            if (shadow_sp == 0) sts = STS_UNDER;
            else if (!slot_reserved(idx)) sts = STS_NOVAR;
            else shadow_vars[idx] = shadow_stack[shadow_sp - 1];
         end
         default: begin
            if (int'(idx) >= VAR_SLOTS) sts = STS_NOVAR;
            else begin
               shadow_vars[idx] = 32'sd0;
               shadow_reserved[idx] = 1'b1;
            end
         end
      endcase
      view.top_value = (shadow_sp == 0) ? 32'sd0 : shadow_stack[shadow_sp - 1];
      view.depth = depth_type'(shadow_sp);
      view.status = sts;
      status_seen[int'(sts)]++;
      if (shadow_sp > deepest_stack) deepest_stack = shadow_sp;
      return view;
   endfunction

   function automatic int draw_wait(bit steady);
      if (steady || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 17);
   endfunction

   task automatic report_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
   endtask

   // send one instruction and predict its result once the transfer happens
   task automatic send_instruction(input action_type act, input word_type imm,
                                   input index_type idx);
      int gap;
      gap = draw_wait(steady_sender);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.action <= act;
      req_if.immediate <= imm;
      req_if.var_index <= idx;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_views.push_back(step_shadow(act, imm, idx));
      instructions_sent++;
   endtask

   // hold off the sender until every predicted result has come back
   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (expected_views.size() != 0);
   endtask

   // result sink with random stalls, checks every transfer in order
   initial begin : result_check
      int             stall;
      stack_view_type want;
      rsp_if.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_wait(steady_receiver);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         results_checked++;
         if (expected_views.size() == 0) begin
            report_failure($sformatf("result with nothing expected: top %h depth %0d status %0d",
                                     rsp_if.top_value, rsp_if.depth, rsp_if.status));
         end else begin
            want = expected_views.pop_front();
            if (rsp_if.top_value !== want.top_value)
               report_failure($sformatf("top_value mismatch, expected %h, got %h",
                                        want.top_value, rsp_if.top_value));
            if (rsp_if.depth !== want.depth)
               report_failure($sformatf("depth mismatch, expected %0d, got %0d",
                                        want.depth, rsp_if.depth));
            if (rsp_if.status !== want.status)
               report_failure($sformatf("status mismatch, expected %s, got %0d",
                                        want.status.name(), rsp_if.status));
         end
      end
   end

   // stimulus helpers for the random programs
   function automatic word_type pick_immediate();
      case ($urandom_range(0, 3))
         0: return word_type'(int'($urandom_range(0, 8)) - 4);
         1: begin
            case ($urandom_range(0, 3))
               0: return word_type'(32'h7FFF_FFFF);
               1: return word_type'(32'h8000_0000);
               2: return word_type'(32'hFFFF_FFFF);
               default: return 32'sd0;
            endcase
         end
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic action_type pick_action(bit tidy, int push_share);
      int r;
      r = $urandom_range(0, 99);
      if (!tidy) return action_type'($urandom_range(0, 7));
      if (shadow_sp < 2) begin
         if (r < 55) return ACT_PUSH;
         if (r < 75) return ACT_GET;
         if (r < 85 || shadow_sp == 0) return ACT_RESERVE;
         return ACT_SAVE;
      end
      // full stack mostly shrinks, sometimes tries to grow
      if (shadow_sp >= STACK_DEPTH && r >= 10)
         return action_type'($urandom_range(int'(ACT_POP), int'(ACT_LESS)));
      if (r < push_share) return ACT_PUSH;
      return action_type'($urandom_range(int'(ACT_POP), int'(ACT_RESERVE)));
   endfunction

   // random programs never reserve the two top slots
   function automatic index_type pick_index(action_type act, bit tidy);
      index_type idx;
      if (act == ACT_RESERVE) return index_type'($urandom_range(0, VAR_INDEX_REACH - 3));
      idx = index_type'($urandom_range(0, VAR_INDEX_REACH - 1));
      if (tidy && (act == ACT_GET || act == ACT_SAVE))
         for (int n = 0; n < 8 && !slot_reserved(idx); n++)
            idx = index_type'($urandom_range(0, VAR_INDEX_REACH - 1));
      return idx;
   endfunction

   // every stack-consuming instruction on an empty stack
   task automatic test_empty_stack_errors();
      send_instruction(ACT_POP, 32'sd0, 4'd0);
      send_instruction(ACT_ADD, 32'sd0, 4'd0);
      send_instruction(ACT_SUB, 32'sd0, 4'd0);
      send_instruction(ACT_LESS, 32'sd0, 4'd0);
      send_instruction(ACT_SAVE, 32'sd0, 4'd3);
      send_instruction(ACT_GET, 32'sd0, 4'd3);
   endtask

   // wrap-around and signed compare
   task automatic test_arithmetic_wrap();
      send_instruction(ACT_PUSH, word_type'(32'h7FFF_FFFF), 4'd0);
      send_instruction(ACT_SUB, 32'sd0, 4'd0);
      send_instruction(ACT_PUSH, 32'sd1, 4'd0);
      send_instruction(ACT_ADD, 32'sd0, 4'd0);
      send_instruction(ACT_PUSH, 32'sd1, 4'd0);
      send_instruction(ACT_SUB, 32'sd0, 4'd0);
      send_instruction(ACT_PUSH, word_type'(32'hFFFF_FFFF), 4'd0);
      send_instruction(ACT_LESS, 32'sd0, 4'd0);
      send_instruction(ACT_PUSH, 32'sd1, 4'd0);
      send_instruction(ACT_LESS, 32'sd0, 4'd0);
      send_instruction(ACT_PUSH, 32'sd1, 4'd0);
      send_instruction(ACT_LESS, 32'sd0, 4'd0);
      send_instruction(ACT_PUSH, word_type'(32'h8000_0000), 4'd0);
      send_instruction(ACT_LESS, 32'sd0, 4'd0);
   endtask

   // reserve, save, get and re-reserve of variable slots
   task automatic test_variable_slots();
      send_instruction(ACT_SAVE, 32'sd0, 4'd3);
      send_instruction(ACT_RESERVE, 32'sd0, 4'd3);
      send_instruction(ACT_GET, 32'sd0, 4'd3);
      send_instruction(ACT_PUSH, word_type'(32'hA5A5_A5A5), 4'd0);
      send_instruction(ACT_SAVE, 32'sd0, 4'd3);
      send_instruction(ACT_POP, 32'sd0, 4'd0);
      send_instruction(ACT_GET, 32'sd0, 4'd3);
      send_instruction(ACT_RESERVE, 32'sd0, 4'd3);
      send_instruction(ACT_GET, 32'sd0, 4'd3);
      send_instruction(ACT_RESERVE, 32'sd0, 4'd15);
      send_instruction(ACT_PUSH, word_type'(32'h5A5A_5A5A), 4'd0);
      send_instruction(ACT_SAVE, 32'sd0, 4'd15);
      send_instruction(ACT_GET, 32'sd0, 4'd15);
      send_instruction(ACT_GET, 32'sd0, 4'd14);
   endtask

   // full stack: overflow, priority of unreserved slot, then back to empty
   task automatic test_stack_limits();
      while (shadow_sp > 0) send_instruction(ACT_POP, 32'sd0, 4'd0);
      while (shadow_sp < STACK_DEPTH)
         send_instruction((shadow_sp % 4 == 3) ? ACT_GET : ACT_PUSH, word_type'($urandom), 4'd15);
      send_instruction(ACT_PUSH, 32'sd7, 4'd0);
      send_instruction(ACT_GET, 32'sd0, 4'd15);
      send_instruction(ACT_GET, 32'sd0, 4'd14);
      send_instruction(ACT_SAVE, 32'sd0, 4'd14);
      for (int k = 0; shadow_sp > 1; k++)
         send_instruction(action_type'(int'(ACT_ADD) + k % 3), 32'sd0, 4'd0);
      send_instruction(ACT_POP, 32'sd0, 4'd0);
      send_instruction(ACT_POP, 32'sd0, 4'd0);
   endtask

   // random programs, mostly well formed, with changing idle behavior
   task automatic test_random_programs(input int count);
      int         push_share;
      bit         tidy;
      action_type act;
      push_share = 35;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            steady_sender = ($urandom_range(0, 3) == 0);
            steady_receiver = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
               0: push_share = 15;
               1: push_share = 35;
               default: push_share = 65;
            endcase
         end
         tidy = ($urandom_range(0, 99) < 85);
         act = pick_action(tidy, push_share);
         send_instruction(act, pick_immediate(), pick_index(act, tidy));
      end
   endtask

   // main sequence
   initial begin
      req_if.valid = 1'b0;
      req_if.action = ACT_PUSH;
      req_if.immediate = 32'sd0;
      req_if.var_index = 4'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_empty_stack_errors();
      wait_for_results();
      test_arithmetic_wrap();
      test_variable_slots();
      wait_for_results();
      test_stack_limits();
      wait_for_results();
      test_random_programs(500);
      wait_for_results();
      repeat (20) @(posedge clock);

      $display("covered %0d instructions, %0d results checked, deepest stack %0d",
               instructions_sent, results_checked, deepest_stack);
      $display("status counts: ok %0d, underflow %0d, overflow %0d, unreserved %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (mismatch_count == 0 && expected_views.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
